// File: rtl/triclinic_minimum_image_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triclinic minimum-image unit
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRICLINIC_MINIMUM_IMAGE_UNIT_MACROS_SVH
`define TRICLINIC_MINIMUM_IMAGE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TMI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define TMI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define TMI_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TMI_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/tmi_pkg.sv
// ----------------------------------------------------------------------------
// tmi_pkg
// Types and constants shared by the triclinic minimum-image unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tmi_pkg;

  localparam int COEFF_W   = 32;  // Q15.16 cell, Q1.30 inverse
  localparam int DIST_W    = 32;  // Q15.16
  localparam int SCALED_W  = 36;  // Q5.30
  localparam int NUM_COEFF = 9;
  localparam int SEL_W     = 5;

  localparam logic [SEL_W-1:0] SEL_INV_BASE = 5'd9;
  localparam logic [SEL_W-1:0] SEL_LIMIT    = 5'd18;

  localparam logic signed [SCALED_W-1:0] HALF_Q30 = 36'sh0_2000_0000;
  localparam logic signed [SCALED_W-1:0] ONE_Q30  = 36'sh0_4000_0000;

  typedef enum logic [0:0] {
    CMD_WRITE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef coeff_t [NUM_COEFF-1:0]    mat_t;

  typedef struct packed {
    logic                      command;
    logic                      box_index;
    logic [SEL_W-1:0]          coeff_select;
    logic signed [COEFF_W-1:0] coeff_value;
    logic signed [DIST_W-1:0]  dist_x;
    logic signed [DIST_W-1:0]  dist_y;
    logic signed [DIST_W-1:0]  dist_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] image_x;
    logic signed [DIST_W-1:0] image_y;
    logic signed [DIST_W-1:0] image_z;
    logic                     overflow;
  } out_item_t;

  // coefficient write request into the store
  typedef struct packed {
    logic               en;
    logic               box;
    logic [SEL_W-1:0]   sel;
    logic [COEFF_W-1:0] value;
  } wr_req_t;

  // sideband carried through the first matrix-vector pass
  typedef struct packed {
    mat_t cel;
    logic oob;
  } p1_tag_t;

  // sideband carried through the second pass
  typedef struct packed {
    logic oob;
    logic ovf;
  } p2_tag_t;

endpackage

`default_nettype wire

// File: rtl/tmi_coeff_store.sv
// ----------------------------------------------------------------------------
// tmi_coeff_store
// Per-box cell and inverse matrices; one small memory per coefficient slot,
// single write port, registered read of a whole matrix pair.
// ----------------------------------------------------------------------------
`default_nettype none

module tmi_coeff_store #(
  parameter int NUM_BOXES = 2
) (
  input  logic             clk,
  input  tmi_pkg::wr_req_t wr,
  input  logic             rd_en,
  input  logic             rd_box,
  output tmi_pkg::mat_t    rd_cel,
  output tmi_pkg::mat_t    rd_inv
);

  localparam int BOX_AW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;

  logic [BOX_AW-1:0] wr_addr;
  logic [BOX_AW-1:0] rd_addr;

  // out-of-range boxes map to entry 0; the top level gates off their writes and discards their reads
  assign wr_addr = (32'(wr.box) < NUM_BOXES) ? BOX_AW'(wr.box) : '0;
  assign rd_addr = (32'(rd_box) < NUM_BOXES) ? BOX_AW'(rd_box) : '0;

  for (genvar c = 0; c < tmi_pkg::NUM_COEFF; c++) begin : g_slot
    logic [tmi_pkg::COEFF_W-1:0] cel_mem [NUM_BOXES];
    logic [tmi_pkg::COEFF_W-1:0] inv_mem [NUM_BOXES];

    always_ff @(posedge clk) begin
      if (wr.en && wr.sel == tmi_pkg::SEL_W'(c)) begin
        cel_mem[wr_addr] <= wr.value;
      end
      if (wr.en && wr.sel == tmi_pkg::SEL_INV_BASE + tmi_pkg::SEL_W'(c)) begin
        inv_mem[wr_addr] <= wr.value;
      end
      if (rd_en) begin
        rd_cel[c] <= cel_mem[rd_addr];
        rd_inv[c] <= inv_mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tmi_matvec.sv
// ----------------------------------------------------------------------------
// tmi_matvec
// 3x3 matrix times vector, three stages: products, row sums, floor scale and
// saturation. Valid/ready per stage so bubbles collapse under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tmi_matvec #(
  parameter int VEC_W = 32,
  parameter int SHIFT = 16,
  parameter int OUT_W = 36,
  parameter int TAG_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tmi_pkg::mat_t              mat,
  input  logic [2:0][VEC_W-1:0]      vec,
  input  logic [TAG_W-1:0]           in_tag,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0][OUT_W-1:0]      res,
  output logic                       res_ovf,
  output logic [TAG_W-1:0]           out_tag
);

  localparam int PROD_W = tmi_pkg::COEFF_W + VEC_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SH_W   = SUM_W - SHIFT;

  localparam logic signed [SH_W-1:0] SAT_MAX =
    {{(SH_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_MIN =
    {{(SH_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic [2:0]               vld_r;
  logic                     rdy_a, rdy_b, rdy_c;

  logic signed [PROD_W-1:0] prod_nxt [9];
  logic signed [PROD_W-1:0] prod_r   [9];
  logic signed [SUM_W-1:0]  sum_nxt  [3];
  logic signed [SUM_W-1:0]  sum_r    [3];
  logic [2:0][OUT_W-1:0]    res_nxt;
  logic [2:0][OUT_W-1:0]    res_r;
  logic [2:0]               sat_nxt;
  logic                     ovf_r;
  logic [TAG_W-1:0]         tag_a_r, tag_b_r, tag_c_r;

  assign rdy_c    = !vld_r[2] || out_ready;
  assign rdy_b    = !vld_r[1] || rdy_c;
  assign rdy_a    = !vld_r[0] || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r*3+c] = $signed(mat[r*3+c]) * $signed(vec[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = prod_r[r*3] + prod_r[r*3+1] + prod_r[r*3+2];
    end
  end

  // floor divide by 2^SHIFT is the upper slice of the exact sum
  always_comb begin
    logic signed [SH_W-1:0] sh;
    for (int r = 0; r < 3; r++) begin
      sh = sum_r[r][SUM_W-1:SHIFT];
      if (sh > SAT_MAX) begin
        res_nxt[r] = SAT_MAX[OUT_W-1:0];
        sat_nxt[r] = 1'b1;
      end else if (sh < SAT_MIN) begin
        res_nxt[r] = SAT_MIN[OUT_W-1:0];
        sat_nxt[r] = 1'b1;
      end else begin
        res_nxt[r] = sh[OUT_W-1:0];
        sat_nxt[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy_a) vld_r[0] <= in_valid;
      if (rdy_b) vld_r[1] <= vld_r[0];
      if (rdy_c) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      prod_r  <= prod_nxt;
      tag_a_r <= in_tag;
    end
    if (rdy_b) begin
      sum_r   <= sum_nxt;
      tag_b_r <= tag_a_r;
    end
    if (rdy_c) begin
      res_r   <= res_nxt;
      ovf_r   <= |sat_nxt;
      tag_c_r <= tag_b_r;
    end
  end

  assign out_valid = vld_r[2];
  assign res       = res_r;
  assign res_ovf   = ovf_r;
  assign out_tag   = tag_c_r;

endmodule

`default_nettype wire

// File: rtl/triclinic_minimum_image_unit.sv
// ----------------------------------------------------------------------------
// triclinic_minimum_image_unit
// Minimum-image separation vector in a triclinic periodic box, fixed point.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low. A write item (command 0)
// stores one coefficient of a box's cell matrix (select 0-8, Q15.16) or
// inverse matrix (select 9-17, Q1.30) on the edge it is accepted and is
// visible to the very next compute item; it gives no result. A compute item
// (command 1) passes through a coefficient read register, then two 3-stage
// matrix-vector pipelines (multiply, row sum, scale/saturate) with a fold
// stage between them, and an output register. Stalls first close the gaps
// between items, so new items keep entering while results wait until the
// pipeline is full.
// Coefficients have no reset; a box must be fully loaded before it is used.
// Computes on a box at or above NUM_BOXES return an all-zero result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triclinic_minimum_image_unit_macros.svh"

module triclinic_minimum_image_unit #(
  parameter int NUM_BOXES = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tmi_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tmi_pkg::out_item_t out_item
);

  localparam int SW = tmi_pkg::SCALED_W;
  localparam int DW = tmi_pkg::DIST_W;

  logic              accept;
  logic              box_ok;
  tmi_pkg::wr_req_t  wr;

  // stage 1: coefficient read
  logic              s1_v_r;
  logic              s1_ready;
  logic [2:0][DW-1:0] s1_d_r;
  logic              s1_oob_r;
  tmi_pkg::mat_t     s1_cel;
  tmi_pkg::mat_t     s1_inv;
  tmi_pkg::p1_tag_t  s1_tag;

  // first pass: scaled coordinates
  logic              mv1_in_ready;
  logic              mv1_out_valid;
  logic [2:0][SW-1:0] mv1_res;
  logic              mv1_ovf;
  tmi_pkg::p1_tag_t  mv1_tag;

  // fold stage
  logic              fold_v_r;
  logic              fold_ready;
  logic [2:0][SW-1:0] fold_nxt;
  logic [2:0][SW-1:0] fold_s_r;
  tmi_pkg::mat_t     fold_cel_r;
  tmi_pkg::p2_tag_t  fold_tag_r;

  // second pass: back to Cartesian
  logic              mv2_in_ready;
  logic              mv2_out_valid;
  logic [2:0][DW-1:0] mv2_res;
  logic              mv2_ovf;
  tmi_pkg::p2_tag_t  mv2_tag;

  // output register
  logic              out_v_r;
  logic              out_ready;
  tmi_pkg::out_item_t out_item_r;

  assign box_ok   = 32'(in_item.box_index) < NUM_BOXES;
  assign s1_ready = !s1_v_r || mv1_in_ready;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && s1_ready;

  always_comb begin
    wr.en    = accept && in_item.command == tmi_pkg::CMD_WRITE && box_ok
               && in_item.coeff_select < tmi_pkg::SEL_LIMIT;
    wr.box   = in_item.box_index;
    wr.sel   = in_item.coeff_select;
    wr.value = in_item.coeff_value;
  end

  tmi_coeff_store #(
    .NUM_BOXES (NUM_BOXES)
  ) u_store (
    .clk    (clk),
    .wr     (wr),
    .rd_en  (s1_ready),
    .rd_box (in_item.box_index),
    .rd_cel (s1_cel),
    .rd_inv (s1_inv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= accept && in_item.command == tmi_pkg::CMD_COMPUTE;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_d_r   <= {in_item.dist_z, in_item.dist_y, in_item.dist_x};
      s1_oob_r <= !box_ok;
    end
  end

  always_comb begin
    s1_tag.cel = s1_cel;
    s1_tag.oob = s1_oob_r;
  end

  tmi_matvec #(
    .VEC_W (DW),
    .SHIFT (16),
    .OUT_W (SW),
    .TAG_W ($bits(tmi_pkg::p1_tag_t))
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_ready  (mv1_in_ready),
    .mat       (s1_inv),
    .vec       (s1_d_r),
    .in_tag    (s1_tag),
    .out_valid (mv1_out_valid),
    .out_ready (fold_ready),
    .res       (mv1_res),
    .res_ovf   (mv1_ovf),
    .out_tag   (mv1_tag)
  );

  // single shift by one box length, not a round to nearest
  always_comb begin
    logic signed [SW-1:0] v;
    for (int r = 0; r < 3; r++) begin
      v = mv1_res[r];
      if (v < -tmi_pkg::HALF_Q30) begin
        fold_nxt[r] = v + tmi_pkg::ONE_Q30;
      end else if (v > tmi_pkg::HALF_Q30) begin
        fold_nxt[r] = v - tmi_pkg::ONE_Q30;
      end else begin
        fold_nxt[r] = v;
      end
    end
  end

  assign fold_ready = !fold_v_r || mv2_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_v_r <= 1'b0;
    end else if (fold_ready) begin
      fold_v_r <= mv1_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_ready) begin
      fold_s_r       <= fold_nxt;
      fold_cel_r     <= mv1_tag.cel;
      fold_tag_r.oob <= mv1_tag.oob;
      fold_tag_r.ovf <= mv1_ovf;
    end
  end

  tmi_matvec #(
    .VEC_W (SW),
    .SHIFT (30),
    .OUT_W (DW),
    .TAG_W ($bits(tmi_pkg::p2_tag_t))
  ) u_unscale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fold_v_r),
    .in_ready  (mv2_in_ready),
    .mat       (fold_cel_r),
    .vec       (fold_s_r),
    .in_tag    (fold_tag_r),
    .out_valid (mv2_out_valid),
    .out_ready (out_ready),
    .res       (mv2_res),
    .res_ovf   (mv2_ovf),
    .out_tag   (mv2_tag)
  );

  assign out_ready = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= mv2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      if (mv2_tag.oob) begin
        out_item_r <= '0;
      end else begin
        out_item_r.image_x  <= mv2_res[0];
        out_item_r.image_y  <= mv2_res[1];
        out_item_r.image_z  <= mv2_res[2];
        out_item_r.overflow <= mv2_tag.ovf || mv2_ovf;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  // input only backs up when the read stage holds an item
  `TMI_ASSERT_IMPL(chk_stall_occupied, clk, rst_n, in_stall, s1_v_r)
  // write items never enter the arithmetic pipeline
  `TMI_ASSERT_NEXT(chk_write_no_entry, clk, rst_n, accept && in_item.command == tmi_pkg::CMD_WRITE, !s1_v_r)
  // a free output register always takes a finished item
  `TMI_ASSERT_NEXT(chk_out_fill, clk, rst_n, mv2_out_valid && !out_v_r, out_v_r)

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for triclinic_minimum_image_unit: loads both boxes,
// runs directed fold/saturation cases, then random separations against an
// internal predictor with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int NBOX  = 2;
  localparam int ITEMS = 1250;

  // --------------------------------------------------------------------------
  // Expected-image tracker: mirrors the coefficient store and predicts images
  // --------------------------------------------------------------------------
  class image_scoreboard;
    tmi_pkg::mat_t      cell_mat [NBOX];
    tmi_pkg::mat_t      inv_mat  [NBOX];
    tmi_pkg::out_item_t expected_images [$];
    int                 errors = 0;

    function logic signed [95:0] saturate(input logic signed [95:0] v, input int bits,
                                          inout logic ovf);
      logic signed [95:0] top;
      top = (96'sd1 <<< (bits - 1)) - 96'sd1;
      if (v > top) begin
        ovf = 1'b1;
        return top;
      end
      if (v < -top - 96'sd1) begin
        ovf = 1'b1;
        return -top - 96'sd1;
      end
      return v;
    endfunction

    function tmi_pkg::out_item_t predict_image(input tmi_pkg::in_item_t it);
      logic signed [95:0] sep [3];
      logic signed [95:0] scaled [3];
      logic signed [95:0] image [3];
      logic signed [95:0] acc, coeff, half, one;
      logic               ovf;
      tmi_pkg::out_item_t img;
      img = '0;
      if (32'(it.box_index) >= NBOX) return img;
      half   = tmi_pkg::HALF_Q30;
      one    = tmi_pkg::ONE_Q30;
      sep[0] = $signed(it.dist_x);
      sep[1] = $signed(it.dist_y);
      sep[2] = $signed(it.dist_z);
      ovf    = 1'b0;
      // scaled coords, Q5.30, then single shift toward the central cell
      for (int r = 0; r < 3; r++) begin
        acc = '0;
        for (int c = 0; c < 3; c++) begin
          coeff = $signed(inv_mat[it.box_index][r*3+c]);
          acc += coeff * sep[c];
        end
        scaled[r] = saturate(acc >>> 16, tmi_pkg::SCALED_W, ovf);
        if (scaled[r] < -half) scaled[r] += one;
        if (scaled[r] > half) scaled[r] -= one;
      end
      for (int r = 0; r < 3; r++) begin
        acc = '0;
        for (int c = 0; c < 3; c++) begin
          coeff = $signed(cell_mat[it.box_index][r*3+c]);
          acc += coeff * scaled[c];
        end
        image[r] = saturate(acc >>> 30, tmi_pkg::DIST_W, ovf);
      end
      img.image_x  = image[0][tmi_pkg::DIST_W-1:0];
      img.image_y  = image[1][tmi_pkg::DIST_W-1:0];
      img.image_z  = image[2][tmi_pkg::DIST_W-1:0];
      img.overflow = ovf;
      return img;
    endfunction

    function void note_item(input tmi_pkg::in_item_t it);
      if (it.command == tmi_pkg::CMD_WRITE) begin
        if (32'(it.box_index) < NBOX && it.coeff_select < tmi_pkg::SEL_LIMIT) begin
          if (it.coeff_select < tmi_pkg::SEL_INV_BASE)
            cell_mat[it.box_index][it.coeff_select] = it.coeff_value;
          else
            inv_mat[it.box_index][it.coeff_select - tmi_pkg::SEL_INV_BASE] = it.coeff_value;
        end
      end else begin
        expected_images.push_back(predict_image(it));
      end
    endfunction

    function void check_image(input tmi_pkg::out_item_t got);
      tmi_pkg::out_item_t want;
      if (expected_images.size() == 0) begin
        $error("image result with no item pending");
        errors++;
        return;
      end
      want = expected_images.pop_front();
      if (got.image_x !== want.image_x) begin
        $error("image_x expected %0d got %0d", want.image_x, got.image_x);
        errors++;
      end
      if (got.image_y !== want.image_y) begin
        $error("image_y expected %0d got %0d", want.image_y, got.image_y);
        errors++;
      end
      if (got.image_z !== want.image_z) begin
        $error("image_z expected %0d got %0d", want.image_z, got.image_z);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow expected %0b got %0b", want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int pending();
      return expected_images.size();
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tmi_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tmi_pkg::out_item_t out_item;

  image_scoreboard sb = new();

  int sent_count = 0;
  int span [NBOX];
  bit gaps_on    = 1'b1;
  bit stall_on   = 1'b1;
  bit calm       = 1'b0;
  int stall_left = 0;

  always #1 clk = ~clk;

  triclinic_minimum_image_unit #(
    .NUM_BOXES (NBOX)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // sink: random stall bursts
  always @(posedge clk) begin
    if (calm || !stall_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_image(out_item);
  end

  task automatic push_item(input tmi_pkg::in_item_t it);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    sent_count++;
  endtask

  function automatic tmi_pkg::in_item_t write_item(input bit box,
                                                   input logic [tmi_pkg::SEL_W-1:0] sel,
                                                   input logic [tmi_pkg::COEFF_W-1:0] val);
    tmi_pkg::in_item_t it;
    it.command      = tmi_pkg::CMD_WRITE;
    it.box_index    = box;
    it.coeff_select = sel;
    it.coeff_value  = val;
    it.dist_x       = $urandom;
    it.dist_y       = $urandom;
    it.dist_z       = $urandom;
    return it;
  endfunction

  function automatic tmi_pkg::in_item_t compute_item(input bit box, input logic [31:0] dx,
                                                     input logic [31:0] dy,
                                                     input logic [31:0] dz);
    tmi_pkg::in_item_t it;
    it.command      = tmi_pkg::CMD_COMPUTE;
    it.box_index    = box;
    it.coeff_select = tmi_pkg::SEL_W'($urandom_range(0, 31));
    it.coeff_value  = $urandom;
    it.dist_x       = dx;
    it.dist_y       = dy;
    it.dist_z       = dz;
    return it;
  endfunction

  // mostly within about one and a half cells, some raw and corner values
  function automatic logic [31:0] pick_dist(input int lim);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) return $urandom_range(0, 2 * lim) - lim;
    if (pick < 17) return $urandom;
    case ($urandom_range(0, 4))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return lim / 3;
      default: return -(lim / 3);
    endcase
  endfunction

  task automatic load_box(input bit box, input tmi_pkg::mat_t cm, input tmi_pkg::mat_t im);
    for (int i = 0; i < tmi_pkg::NUM_COEFF; i++)
      push_item(write_item(box, tmi_pkg::SEL_W'(i), cm[i]));
    for (int i = 0; i < tmi_pkg::NUM_COEFF; i++)
      push_item(write_item(box, tmi_pkg::SEL_INV_BASE + tmi_pkg::SEL_W'(i), im[i]));
  endtask

  // upper-triangular cell with tilts, or a raw random box for saturation
  task automatic make_box(input bit box);
    real           a, b, c, d, e, f, big;
    tmi_pkg::mat_t cm, im;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < tmi_pkg::NUM_COEFF; i++) begin
        cm[i] = $urandom;
        im[i] = $urandom;
      end
      span[box] = 1 << 20;
    end else begin
      a  = 4.0 + 28.0 * $urandom_range(0, 1000) / 1000.0;
      d  = 4.0 + 28.0 * $urandom_range(0, 1000) / 1000.0;
      f  = 4.0 + 28.0 * $urandom_range(0, 1000) / 1000.0;
      b  = a * ($urandom_range(0, 1000) / 1000.0 - 0.5);
      c  = a * ($urandom_range(0, 1000) / 1000.0 - 0.5);
      e  = d * ($urandom_range(0, 1000) / 1000.0 - 0.5);
      cm = '0;
      im = '0;
      cm[0] = $rtoi(a * 65536.0);
      cm[1] = $rtoi(b * 65536.0);
      cm[2] = $rtoi(c * 65536.0);
      cm[4] = $rtoi(d * 65536.0);
      cm[5] = $rtoi(e * 65536.0);
      cm[8] = $rtoi(f * 65536.0);
      im[0] = $rtoi(1073741824.0 / a);
      im[1] = $rtoi(-b / (a * d) * 1073741824.0);
      im[2] = $rtoi((b * e - c * d) / (a * d * f) * 1073741824.0);
      im[4] = $rtoi(1073741824.0 / d);
      im[5] = $rtoi(-e / (d * f) * 1073741824.0);
      im[8] = $rtoi(1073741824.0 / f);
      big = a;
      if (d > big) big = d;
      if (f > big) big = f;
      span[box] = $rtoi(big * 65536.0 * 1.6);
    end
    load_box(box, cm, im);
  endtask

  initial begin
    tmi_pkg::mat_t cm, im;
    bit            box;
    int            next_shuffle;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // box 0: unit cell, unit inverse -> image is the folded separation
    cm    = '0;
    im    = '0;
    cm[0] = 32'sh0001_0000;
    cm[4] = 32'sh0001_0000;
    cm[8] = 32'sh0001_0000;
    im[0] = 32'sh4000_0000;
    im[4] = 32'sh4000_0000;
    im[8] = 32'sh4000_0000;
    load_box(1'b0, cm, im);
    // box 1: extreme cell rows, inverse -2.0 on the diagonal
    cm = '0;
    im = '0;
    for (int i = 0; i < 3; i++) begin
      cm[i]     = 32'h7fff_ffff;
      cm[3 + i] = 32'h8000_0000;
    end
    cm[6] = 32'h7fff_ffff;
    cm[7] = 32'h8000_0000;
    im[0] = 32'h8000_0000;
    im[4] = 32'h8000_0000;
    im[8] = 32'h8000_0000;
    load_box(1'b1, cm, im);

    push_item(compute_item(1'b0, 32'd0, 32'd0, 32'd0));
    // exactly on the half-cell boundary: no shift
    push_item(compute_item(1'b0, 32'd32768, -32'sd32768, 32'd32767));
    // one lsb past it, and a full cell
    push_item(compute_item(1'b0, 32'd32769, -32'sd32769, 32'd65536));
    // scaled saturation both ways
    push_item(compute_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'd98304));
    push_item(compute_item(1'b0, -32'sd98304, 32'd98304, -32'sd65537));
    // out-of-range selects leave the store alone
    push_item(write_item(1'b0, 5'd31, 32'h1234_5678));
    push_item(write_item(1'b1, tmi_pkg::SEL_LIMIT, 32'hffff_ffff));
    push_item(compute_item(1'b0, 32'd32769, 32'd1, -32'sd1));
    // result saturation, positive and negative rows
    push_item(compute_item(1'b1, -32'sd13107, -32'sd13107, -32'sd13107));
    push_item(compute_item(1'b1, 32'd13107, 32'd13107, 32'd13107));
    push_item(compute_item(1'b1, 32'd19661, -32'sd19661, 32'd0));
    push_item(compute_item(1'b1, 32'd0, 32'd0, 32'd0));

    make_box(1'b0);
    make_box(1'b1);
    next_shuffle = sent_count;
    while (sent_count < ITEMS) begin
      if (sent_count >= next_shuffle) begin
        gaps_on      = $urandom_range(0, 2) != 0;
        stall_on     = $urandom_range(0, 2) != 0;
        next_shuffle = next_shuffle + 100;
      end
      calm = sent_count >= ITEMS - 150;
      box  = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 199)) inside
        [0:1]:   make_box(box);
        [2:9]:   push_item(write_item(box, tmi_pkg::SEL_W'($urandom_range(18, 31)),
                                      $urandom));
        [10:14]: push_item(write_item(box, tmi_pkg::SEL_W'($urandom_range(0, 17)),
                                      $urandom));
        default: push_item(compute_item(box, pick_dist(span[box]), pick_dist(span[box]),
                                        pick_dist(span[box])));
      endcase
    end
    calm = 1'b1;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0)
      $display("[triclinic_minimum_image_unit] OK");
    else
      $display("[triclinic_minimum_image_unit] ERROR");
    $finish;
  end

  initial begin
    #200000;
    $display("[triclinic_minimum_image_unit] ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/tmi_pkg.sv
rtl/tmi_coeff_store.sv
rtl/tmi_matvec.sv
rtl/triclinic_minimum_image_unit.sv
tb/sv/tb.sv
